// File: design/assert_macros.svh
// Assertion macros shared by the cursor tape editor RTL.
// Each macro expects clk_i and rst_ni in the scope of its use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CTE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ctep_pkg.sv
// Package for the cursor tape editor: tape size, command and status codes,
// and the control structs that travel from the core to the tape cells.
`timescale 1ns / 1ps

package ctep_pkg;

  localparam int TAPE_LEN = 64;
  localparam int IDX_W    = 6;
  localparam int LEN_W    = 7;
  localparam int CHAR_W   = 8;

  localparam logic [CHAR_W-1:0] FILL_CHAR = 8'h23;

  typedef enum logic [2:0] {
    FUNC_MOVE_LEFT       = 3'd0,
    FUNC_MOVE_RIGHT      = 3'd1,
    FUNC_MOVE_LEFT_CHAR  = 3'd2,
    FUNC_MOVE_RIGHT_CHAR = 3'd3,
    FUNC_WRITE           = 3'd4,
    FUNC_INSERT_LEFT     = 3'd5,
    FUNC_INSERT_RIGHT    = 3'd6
  } ctep_func_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_ERR  = 2'd1,
    STATUS_FULL = 2'd2
  } ctep_status_e;

  // Broadcast to every cell in the cycle a command word is accepted.
  typedef struct packed {
    logic              capture;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  cursor;
    logic [LEN_W-1:0]  used;
  } ctep_probe_t;

  // Broadcast to every cell in the cycle a command is committed.
  typedef struct packed {
    logic              go;
    logic              shift_en;
    logic              wr_en;
    logic [IDX_W-1:0]  pos;
    logic [CHAR_W-1:0] wr_ch;
    logic [LEN_W-1:0]  used;
  } ctep_commit_t;

  // Characters a cell offers when it sits at, just below or just above the cursor.
  typedef struct packed {
    logic [CHAR_W-1:0] cur;
    logic [CHAR_W-1:0] lft;
    logic [CHAR_W-1:0] rgt;
  } ctep_tap_t;

  // Nearest match on each side of the cursor.
  typedef struct packed {
    logic             found_l;
    logic [IDX_W-1:0] idx_l;
    logic             found_r;
    logic [IDX_W-1:0] idx_r;
  } ctep_pick_t;

endpackage

// File: design/ctep_cell.sv
// One tape cell: holds a character, takes its lower neighbor's character on
// an insert shift, and flags a match against the probe. Uses ctep_pkg.
`timescale 1ns / 1ps

module ctep_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [ctep_pkg::IDX_W-1:0]     idx_i,
  input  logic [ctep_pkg::CHAR_W-1:0]    rst_val_i,
  input  ctep_pkg::ctep_probe_t          probe_i,
  input  ctep_pkg::ctep_commit_t         commit_i,
  input  logic [ctep_pkg::CHAR_W-1:0]    left_i,
  output logic [ctep_pkg::CHAR_W-1:0]    char_o,
  output ctep_pkg::ctep_tap_t            tap_o,
  output logic                           match_l_o,
  output logic                           match_r_o
);
  import ctep_pkg::*;

  logic [CHAR_W-1:0] char_q, char_d;
  logic              match_l_q, match_r_q;
  logic              hit;
  logic              in_shift;
  logic              is_cur, is_lft, is_rgt;

  // Locate this cell relative to the cursor.
  assign hit    = (char_q == probe_i.ch);
  assign is_cur = (idx_i == probe_i.cursor);
  assign is_lft = ((idx_i + IDX_W'(1)) == probe_i.cursor);
  assign is_rgt = (idx_i == (probe_i.cursor + IDX_W'(1)));

  // Offer the held character on the matching tap, zero elsewhere.
  assign tap_o.cur = is_cur ? char_q : '0;
  assign tap_o.lft = is_lft ? char_q : '0;
  assign tap_o.rgt = is_rgt ? char_q : '0;

  // Shift up when the cell lies above the opened slot and inside the tape.
  assign in_shift = commit_i.shift_en && (idx_i > commit_i.pos) &&
                    ({1'b0, idx_i} <= commit_i.used);

  always_comb begin
    char_d = char_q;
    if (commit_i.go) begin
      if (in_shift) begin
        char_d = left_i;
      end
      if (commit_i.wr_en && (idx_i == commit_i.pos)) begin
        char_d = commit_i.wr_ch;
      end
    end
  end

  // Hold the character; load on commit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q <= rst_val_i;
    end else begin
      char_q <= char_d;
    end
  end

  // Capture match flags, masked to each search range, when a word is accepted.
  always_ff @(posedge clk_i) begin
    if (probe_i.capture) begin
      match_l_q <= hit && (idx_i <= probe_i.cursor);
      match_r_q <= hit && (idx_i >= probe_i.cursor) && ({1'b0, idx_i} < probe_i.used);
    end
  end

  assign char_o    = char_q;
  assign match_l_o = match_l_q;
  assign match_r_o = match_r_q;

endmodule

// File: design/ctep_pick.sv
// Nearest-match pick over the captured cell match flags: highest flag at or
// below the cursor, lowest flag at or above it. Uses ctep_pkg.
`timescale 1ns / 1ps

module ctep_pick (
  input  logic [ctep_pkg::TAPE_LEN-1:0] match_l_i,
  input  logic [ctep_pkg::TAPE_LEN-1:0] match_r_i,
  output ctep_pkg::ctep_pick_t          pick_o
);
  import ctep_pkg::*;

  logic [TAPE_LEN-1:0] rev_l;
  logic [TAPE_LEN-1:0] iso_l, iso_r;
  logic [IDX_W-1:0]    pos_rev_l, pos_r;

  // Reverse the left flags so the highest one becomes the lowest.
  always_comb begin
    for (int i = 0; i < TAPE_LEN; i++) begin
      rev_l[i] = match_l_i[TAPE_LEN-1-i];
    end
  end

  // Isolate the lowest set flag with one add.
  assign iso_l = rev_l & (~rev_l + TAPE_LEN'(1));
  assign iso_r = match_r_i & (~match_r_i + TAPE_LEN'(1));

  // Encode the one-hot flags.
  always_comb begin
    pos_rev_l = '0;
    pos_r     = '0;
    for (int i = 0; i < TAPE_LEN; i++) begin
      if (iso_l[i]) pos_rev_l = pos_rev_l | IDX_W'(i);
      if (iso_r[i]) pos_r     = pos_r | IDX_W'(i);
    end
  end

  assign pick_o.found_l = |match_l_i;
  assign pick_o.idx_l   = IDX_W'(TAPE_LEN - 1) - pos_rev_l;
  assign pick_o.found_r = |match_r_i;
  assign pick_o.idx_r   = pos_r;

endmodule

// File: design/cursor_tape_editor_core.sv
// Top level of the cursor tape editor: a row of tape cells, the nearest-match
// pick and the command sequencer. Uses ctep_pkg, ctep_cell, ctep_pick.
`timescale 1ns / 1ps

// A command word passes the idle and evaluation states: in the cycle it is
// accepted every cell compares its character with ch and captures its match
// flags and the characters around the cursor; in the evaluation state the
// pick finds the nearest match; on commit the cells write or shift in one
// step and the result word is loaded into the output register. A new command
// is taken only after the last one commits; a stalled result holds the
// evaluation state until its predecessor leaves the output register. The tape
// holds 64 cells, reset directly to a single '#' cell with the cursor on it.
module cursor_tape_editor_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [2:0]                         func_i,
  input  logic [ctep_pkg::CHAR_W-1:0]        ch_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         status_o,
  output logic [ctep_pkg::CHAR_W-1:0]        cursor_char_o,
  output logic [ctep_pkg::IDX_W-1:0]         cursor_pos_o,
  output logic [ctep_pkg::LEN_W-1:0]         tape_length_o
);
  import ctep_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } state_e;

  state_e             state_q;
  logic [IDX_W-1:0]   cursor_q, cursor_d;
  logic [LEN_W-1:0]   used_q, used_d;
  logic [2:0]         func_q;
  logic [CHAR_W-1:0]  ch_q;
  logic [CHAR_W-1:0]  cur_q, lft_q, rgt_q;
  logic               out_valid_q;
  logic [1:0]         status_q;
  logic [CHAR_W-1:0]  out_char_q;
  logic [IDX_W-1:0]   out_pos_q;
  logic [LEN_W-1:0]   out_len_q;

  logic               in_acc;
  logic               commit;
  ctep_probe_t        probe;
  ctep_commit_t       cmt;
  ctep_pick_t         pick;
  ctep_tap_t          taps [TAPE_LEN];
  logic [CHAR_W-1:0]  chars [TAPE_LEN];
  logic [TAPE_LEN-1:0] match_l, match_r;
  logic [CHAR_W-1:0]  tap_cur, tap_lft, tap_rgt;

  ctep_status_e       status_d;
  logic [CHAR_W-1:0]  char_d;
  logic               full;
  logic               at_end;

  // Accept only while idle; commit once the output register is free.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign commit     = (state_q == ST_EVAL) && (!out_valid_q || !out_stall_i);

  assign probe.capture = in_acc;
  assign probe.ch      = ch_i;
  assign probe.cursor  = cursor_q;
  assign probe.used    = used_q;

  // Build the row of cells, each fed by its lower neighbor.
  for (genvar g = 0; g < TAPE_LEN; g++) begin : g_cells
    logic [CHAR_W-1:0] left_ch;
    if (g == 0) begin : g_first
      assign left_ch = '0;
    end else begin : g_rest
      assign left_ch = chars[g-1];
    end
    ctep_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .idx_i     (IDX_W'(g)),
      .rst_val_i ((g == 0) ? FILL_CHAR : CHAR_W'(0)),
      .probe_i   (probe),
      .commit_i  (cmt),
      .left_i    (left_ch),
      .char_o    (chars[g]),
      .tap_o     (taps[g]),
      .match_l_o (match_l[g]),
      .match_r_o (match_r[g])
    );
  end

  ctep_pick u_pick (
    .match_l_i (match_l),
    .match_r_i (match_r),
    .pick_o    (pick)
  );

  // Merge the cursor taps; at most one cell drives each.
  always_comb begin
    tap_cur = '0;
    tap_lft = '0;
    tap_rgt = '0;
    for (int i = 0; i < TAPE_LEN; i++) begin
      tap_cur = tap_cur | taps[i].cur;
      tap_lft = tap_lft | taps[i].lft;
      tap_rgt = tap_rgt | taps[i].rgt;
    end
  end

  // Capture operands and cursor neighborhood with the accepted word.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= func_i;
      ch_q   <= ch_i;
      cur_q  <= tap_cur;
      lft_q  <= tap_lft;
      rgt_q  <= tap_rgt;
    end
  end

  assign full   = (used_q == LEN_W'(TAPE_LEN));
  assign at_end = (({1'b0, cursor_q} + LEN_W'(1)) == used_q);

  // Decide the command outcome and the cell update.
  always_comb begin
    status_d     = STATUS_OK;
    cursor_d     = cursor_q;
    used_d       = used_q;
    char_d       = cur_q;
    cmt.go       = commit;
    cmt.shift_en = 1'b0;
    cmt.wr_en    = 1'b0;
    cmt.pos      = cursor_q;
    cmt.wr_ch    = ch_q;
    cmt.used     = used_q;
    unique case (ctep_func_e'(func_q))
      FUNC_MOVE_LEFT: begin
        if (cursor_q != '0) begin
          cursor_d = cursor_q - IDX_W'(1);
          char_d   = lft_q;
        end
      end
      FUNC_MOVE_RIGHT, FUNC_MOVE_RIGHT_CHAR: begin
        if ((ctep_func_e'(func_q) == FUNC_MOVE_RIGHT_CHAR) && pick.found_r) begin
          cursor_d = pick.idx_r;
          char_d   = ch_q;
        end else if ((ctep_func_e'(func_q) == FUNC_MOVE_RIGHT) && !at_end) begin
          cursor_d = cursor_q + IDX_W'(1);
          char_d   = rgt_q;
        end else if (full) begin
          status_d = STATUS_FULL;
        end else begin
          // Append a fill cell and step onto it.
          cmt.wr_en = 1'b1;
          cmt.pos   = used_q[IDX_W-1:0];
          cmt.wr_ch = FILL_CHAR;
          cursor_d  = used_q[IDX_W-1:0];
          used_d    = used_q + LEN_W'(1);
          char_d    = FILL_CHAR;
        end
      end
      FUNC_MOVE_LEFT_CHAR: begin
        if (pick.found_l) begin
          cursor_d = pick.idx_l;
          char_d   = ch_q;
        end else begin
          status_d = STATUS_ERR;
        end
      end
      FUNC_WRITE: begin
        cmt.wr_en = 1'b1;
        char_d    = ch_q;
      end
      FUNC_INSERT_LEFT: begin
        if (cursor_q == '0) begin
          status_d = STATUS_ERR;
        end else if (full) begin
          status_d = STATUS_FULL;
        end else begin
          cmt.shift_en = 1'b1;
          cmt.wr_en    = 1'b1;
          used_d       = used_q + LEN_W'(1);
          char_d       = ch_q;
        end
      end
      FUNC_INSERT_RIGHT: begin
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          cmt.shift_en = 1'b1;
          cmt.wr_en    = 1'b1;
          cmt.pos      = cursor_q + IDX_W'(1);
          cursor_d     = cursor_q + IDX_W'(1);
          used_d       = used_q + LEN_W'(1);
          char_d       = ch_q;
        end
      end
      default: begin
        status_d = STATUS_ERR;
      end
    endcase
  end

  // Sequence the command, advance cursor and length, load the result word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cursor_q    <= '0;
      used_q      <= LEN_W'(1);
      out_valid_q <= 1'b0;
      status_q    <= '0;
      out_char_q  <= '0;
      out_pos_q   <= '0;
      out_len_q   <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (commit) begin
            state_q     <= ST_IDLE;
            cursor_q    <= cursor_d;
            used_q      <= used_d;
            out_valid_q <= 1'b1;
            status_q    <= status_d;
            out_char_q  <= char_d;
            out_pos_q   <= cursor_d;
            out_len_q   <= used_d;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign cursor_char_o = out_char_q;
  assign cursor_pos_o  = out_pos_q;
  assign tape_length_o = out_len_q;

  `CTE_ASSERT_NOW(a_len_range, 1'b1, (used_q != '0) && (used_q <= LEN_W'(TAPE_LEN)), "tape length out of range")
  `CTE_ASSERT_NOW(a_cursor_in_tape, 1'b1, {1'b0, cursor_q} < used_q, "cursor beyond tape end")
  `CTE_ASSERT_NEXT(a_accept_to_eval, in_acc, state_q == ST_EVAL, "accepted word not evaluated")
  `CTE_ASSERT_NEXT(a_len_step, 1'b1, (used_q == $past(used_q)) || (used_q == $past(used_q) + LEN_W'(1)), "tape length jumped")
  `CTE_ASSERT_NOW(a_no_commit_idle, state_q == ST_IDLE, !commit, "commit outside evaluation")

endmodule
